// ===== src/barcode_whitelist_one_mismatch_match_top_defines.svh =====
// Assertion macros shared by the barcode whitelist matcher RTL.
// No dependencies; included inside module bodies.
`ifndef BARCODE_WHITELIST_ONE_MISMATCH_MATCH_TOP_DEFINES_SVH
`define BARCODE_WHITELIST_ONE_MISMATCH_MATCH_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BWM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bwm_pkg.sv =====
// Shared types, constants and compare/merge functions for the barcode matcher.
// No dependencies.
package bwm_pkg;

    localparam int BASES_W        = 64;
    localparam int ENTRY_W        = BASES_W + 1;   // {valid, code}
    localparam int SLOT_W         = 12;
    localparam int INDEX_W        = 13;
    localparam int LEN_W          = 6;
    localparam int COUNT_W        = 13;
    localparam int STATUS_W       = 2;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int MAX_BASES      = 32;
    localparam int BASES_PER_WORD = 32;

    localparam logic [BASES_W-1:0] BASE_LSB_MASK = 64'h5555_5555_5555_5555;

    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXACT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CORR  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_AMBIG = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_BARCODE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT    = 2'd1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // partial match summary over a set of slots; merge is order independent
    typedef struct packed {
        logic                exact;
        logic [SLOT_W-1:0]   exact_slot;
        logic                near;
        logic                amb;
        logic [SLOT_W-1:0]   near_slot;
        logic [BASES_W-1:0]  near_code;
    } t_acc;

    localparam t_acc ACC_EMPTY = '0;

    function automatic logic [BASES_W-1:0] f_base_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]   eff;
        logic [LEN_W:0]     sh;
        logic [BASES_W-1:0] m;
        eff = len;
        if (eff == '0) eff = LEN_W'(1);
        if (eff > LEN_W'(MAX_BASES)) eff = LEN_W'(MAX_BASES);
        sh = {eff, 1'b0};
        if (eff >= LEN_W'(BASES_PER_WORD)) begin
            m = '1;
        end else begin
            m = (BASES_W'(1) << sh) - BASES_W'(1);
        end
        return m;
    endfunction

    function automatic logic f_one_base_apart(input logic [BASES_W-1:0] a,
                                              input logic [BASES_W-1:0] b);
        logic [BASES_W-1:0] x;
        logic [BASES_W-1:0] pb;
        x  = a ^ b;
        pb = (x | (x >> 1)) & BASE_LSB_MASK;
        return (pb != '0) && ((pb & (pb - BASES_W'(1))) == '0);
    endfunction

    function automatic t_acc f_merge(input t_acc a, input t_acc b);
        t_acc r;
        r.exact = a.exact | b.exact;
        if (a.exact && b.exact) begin
            r.exact_slot = (a.exact_slot > b.exact_slot) ? a.exact_slot : b.exact_slot;
        end else begin
            r.exact_slot = a.exact ? a.exact_slot : b.exact_slot;
        end
        r.near      = a.near | b.near;
        r.amb       = a.amb | b.amb | (a.near && b.near && (a.near_code != b.near_code));
        r.near_code = a.near ? a.near_code : b.near_code;
        if (a.near && b.near) begin
            r.near_slot = (a.near_slot > b.near_slot) ? a.near_slot : b.near_slot;
        end else begin
            r.near_slot = a.near ? a.near_slot : b.near_slot;
        end
        return r;
    endfunction

endpackage

// ===== src/bwm_cell.sv =====
// One cell of the matcher chain: a bank of whitelist slots plus compare/merge.
// Depends on bwm_pkg.
module bwm_cell #(
    parameter int CELL_ID = 0,
    parameter int CELL_W  = 3,
    parameter int ROWS    = 512,
    parameter int ROW_W   = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tok_valid,
    input  logic [ROW_W-1:0]              i_tok_row,
    input  bwm_pkg::t_acc                 i_acc,
    input  logic                          i_wr_en,
    input  logic [ROW_W-1:0]              i_wr_row,
    input  logic [bwm_pkg::ENTRY_W-1:0]   i_wr_data,
    input  logic [bwm_pkg::BASES_W-1:0]   i_query,
    input  logic [bwm_pkg::BASES_W-1:0]   i_mask,
    input  logic [bwm_pkg::COUNT_W-1:0]   i_count,
    output logic                          o_tok_valid,
    output logic [ROW_W-1:0]              o_tok_row,
    output bwm_pkg::t_acc                 o_acc
);
    import bwm_pkg::*;

    localparam int SLOT_FULL_W = ROW_W + CELL_W;
    localparam int CMP_W       = (SLOT_FULL_W > COUNT_W) ? SLOT_FULL_W : COUNT_W;

    logic [ENTRY_W-1:0]     r_mem [ROWS];
    logic [ENTRY_W-1:0]     r_rd;
    logic                   r_s1_valid;
    logic [ROW_W-1:0]       r_s1_row;
    t_acc                   r_s1_acc;
    logic                   r_out_valid;
    logic [ROW_W-1:0]       r_out_row;
    t_acc                   r_out_acc;

    logic [SLOT_FULL_W-1:0] w_slot_full;
    logic [SLOT_W-1:0]      w_slot;
    logic [BASES_W-1:0]     w_code;
    logic                   w_live;
    t_acc                   w_own;
    t_acc                   n_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        r_rd <= r_mem[i_tok_row];
    end

    // stage 1 waits for the bank read; stage 2 holds the merged summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_tok_valid;
            r_out_valid <= r_s1_valid;
        end
        r_s1_row  <= i_tok_row;
        r_s1_acc  <= i_acc;
        r_out_row <= r_s1_row;
        r_out_acc <= n_acc;
    end

    always_comb begin
        w_slot_full = {r_s1_row, CELL_W'(CELL_ID)};
        // a valid entry always sits below the slot port's range
        w_slot      = SLOT_W'(w_slot_full);
        w_code      = r_rd[BASES_W-1:0] & i_mask;
        w_live      = r_rd[BASES_W] && (CMP_W'(w_slot_full) < CMP_W'(i_count));
        w_own       = ACC_EMPTY;
        if (w_live) begin
            if (w_code == i_query) begin
                w_own.exact      = 1'b1;
                w_own.exact_slot = w_slot;
            end else if (f_one_base_apart(w_code, i_query)) begin
                w_own.near       = 1'b1;
                w_own.near_slot  = w_slot;
                w_own.near_code  = w_code;
            end
        end
        n_acc = f_merge(r_s1_acc, w_own);
    end

    assign o_tok_valid = r_out_valid;
    assign o_tok_row   = r_out_row;
    assign o_acc       = r_out_acc;

endmodule

// ===== src/barcode_whitelist_one_mismatch_match_top.sv =====
// Barcode whitelist matcher with single-mismatch correction, top level.
// Depends on bwm_pkg, bwm_cell and barcode_whitelist_one_mismatch_match_top_defines.svh.
//
// The whitelist is split over N_CELLS chained cells; slot s lives in cell s mod N_CELLS,
// row s / N_CELLS. A load is written into its cell's bank as it is accepted. A query
// streams row numbers 0..ROWS-1 into the chain, one per cycle, where ROWS =
// ceil(WL_DEPTH / N_CELLS), and each row's partial result picks up every cell's compare
// on its way down through the cell registers; the scan over every row follows from the
// one read port per cell bank. A query carrying a non-ACGT symbol skips the scan and
// goes straight to the done state. Items are taken one at a time; a finished result sits
// in the output register while the next item is accepted. After reset a clearing pass
// over all ROWS rows invalidates every slot, during which no item is accepted.
// N_CELLS must be a power of two from 2 to 64.
module barcode_whitelist_one_mismatch_match_top #(
    parameter int WL_DEPTH = 4096,
    parameter int N_CELLS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_kind,
    input  logic [bwm_pkg::SLOT_W-1:0]        i_slot,
    input  logic [bwm_pkg::BASES_W-1:0]       i_bases,
    input  logic                              i_has_other_symbol,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bwm_pkg::STATUS_W-1:0]      o_status,
    output logic [bwm_pkg::INDEX_W-1:0]       o_match_index,
    output logic [bwm_pkg::BASES_W-1:0]       o_matched_bases,
    input  logic                              i_cfg_wr_en,
    input  logic [bwm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [bwm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bwm_pkg::*;
    `include "barcode_whitelist_one_mismatch_match_top_defines.svh"

    localparam int CELL_W = $clog2(N_CELLS);
    localparam int ROWS   = (WL_DEPTH + N_CELLS - 1) / N_CELLS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH_W = $clog2(WL_DEPTH + 1) + 1;
    localparam int SCMP_W  = (DEPTH_W > SLOT_W) ? DEPTH_W : SLOT_W;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]           r_state;
    logic [ROW_W-1:0]     r_clr_row;
    logic [ROW_W-1:0]     r_iss_row;
    logic                 r_issuing;
    logic [LEN_W-1:0]     r_len;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   r_q_count;
    logic [BASES_W-1:0]   r_query;
    logic [BASES_W-1:0]   r_mask;
    t_acc                 r_total;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [INDEX_W-1:0]   r_out_index;
    logic [BASES_W-1:0]   r_out_bases;

    logic                 w_accept;
    logic                 w_load;
    logic                 w_slot_ok;
    logic [ROW_W-1:0]     w_wr_row;
    logic [ENTRY_W-1:0]   w_wr_data;
    logic [N_CELLS-1:0]   w_wr_en;
    logic [BASES_W-1:0]   w_len_mask;
    logic                 w_out_free;
    logic                 w_end_valid;
    logic [ROW_W-1:0]     w_end_row;
    t_acc                 w_end_acc;
    logic [STATUS_W-1:0]  w_res_status;
    logic [INDEX_W-1:0]   w_res_index;
    logic [BASES_W-1:0]   w_res_bases;

    logic                 w_tok_valid [N_CELLS+1];
    logic [ROW_W-1:0]     w_tok_row   [N_CELLS+1];
    t_acc                 w_acc       [N_CELLS+1];

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_slot_ok  = SCMP_W'(i_slot) < SCMP_W'(WL_DEPTH);
    assign w_load     = w_accept && (i_kind == KIND_LOAD) && w_slot_ok;
    assign w_len_mask = f_base_mask(r_len);
    assign w_out_free = !r_out_valid || !i_stall;

    // write port shared by loads and the clearing pass
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_wr_row  = r_clr_row;
            w_wr_data = '0;
            w_wr_en   = '1;
        end else begin
            w_wr_row  = ROW_W'(i_slot >> CELL_W);
            w_wr_data = {!i_has_other_symbol, i_bases};
            w_wr_en   = '0;
            w_wr_en[i_slot[CELL_W-1:0]] = w_load;
        end
    end

    assign w_tok_valid[0] = (r_state == ST_SCAN) && r_issuing;
    assign w_tok_row[0]   = r_iss_row;
    assign w_acc[0]       = ACC_EMPTY;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        bwm_cell #(
            .CELL_ID (k),
            .CELL_W  (CELL_W),
            .ROWS    (ROWS),
            .ROW_W   (ROW_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok_valid (w_tok_valid[k]),
            .i_tok_row   (w_tok_row[k]),
            .i_acc       (w_acc[k]),
            .i_wr_en     (w_wr_en[k]),
            .i_wr_row    (w_wr_row),
            .i_wr_data   (w_wr_data),
            .i_query     (r_query),
            .i_mask      (r_mask),
            .i_count     (r_q_count),
            .o_tok_valid (w_tok_valid[k+1]),
            .o_tok_row   (w_tok_row[k+1]),
            .o_acc       (w_acc[k+1])
        );
    end

    assign w_end_valid = w_tok_valid[N_CELLS];
    assign w_end_row   = w_tok_row[N_CELLS];
    assign w_end_acc   = w_acc[N_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_W'(16);
            r_count <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BARCODE_LENGTH: r_len   <= i_cfg_data[LEN_W-1:0];
                CFG_ENTRY_COUNT:    r_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_row   <= '0;
            r_iss_row   <= '0;
            r_issuing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_row <= r_clr_row + ROW_W'(1);
                    if (r_clr_row == LAST_ROW) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept && (i_kind == KIND_QUERY)) begin
                        r_iss_row <= '0;
                        r_issuing <= !i_has_other_symbol;
                        r_state   <= i_has_other_symbol ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_issuing) begin
                        r_iss_row <= r_iss_row + ROW_W'(1);
                        if (r_iss_row == LAST_ROW) begin
                            r_issuing <= 1'b0;
                        end
                    end
                    if (w_end_valid && (w_end_row == LAST_ROW)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // query context and running result
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_query   <= i_bases & w_len_mask;
            r_mask    <= w_len_mask;
            r_q_count <= r_count;
            r_total   <= ACC_EMPTY;
        end else if (r_state == ST_SCAN && w_end_valid) begin
            r_total   <= f_merge(r_total, w_end_acc);
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_status <= w_res_status;
            r_out_index  <= w_res_index;
            r_out_bases  <= w_res_bases;
        end
    end

    always_comb begin
        w_res_status = STATUS_NONE;
        w_res_index  = '0;
        w_res_bases  = '0;
        if (r_total.exact) begin
            w_res_status = STATUS_EXACT;
            w_res_index  = INDEX_W'(r_total.exact_slot) + INDEX_W'(1);
            w_res_bases  = r_query;
        end else if (r_total.amb) begin
            w_res_status = STATUS_AMBIG;
        end else if (r_total.near) begin
            w_res_status = STATUS_CORR;
            w_res_index  = INDEX_W'(r_total.near_slot) + INDEX_W'(1);
            w_res_bases  = r_total.near_code;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_match_index   = r_out_index;
    assign o_matched_bases = r_out_bases;

    `BWM_ASSERT_NOW(a_chain_only_in_scan, i_clk, i_rst_n, w_end_valid, r_state == ST_SCAN, "chain output outside a scan")
    `BWM_ASSERT_NOW(a_last_row_after_issue, i_clk, i_rst_n, (r_state == ST_SCAN) && w_end_valid && (w_end_row == LAST_ROW), !r_issuing, "last row left the chain while rows still issuing")
    `BWM_ASSERT_NEXT(a_done_waits_for_output, i_clk, i_rst_n, (r_state == ST_DONE) && r_out_valid && i_stall, r_state == ST_DONE, "result overwrote an untaken result")
    `BWM_ASSERT_NOW(a_no_answer_no_index, i_clk, i_rst_n, o_valid && ((o_status == STATUS_NONE) || (o_status == STATUS_AMBIG)), (o_match_index == '0) && (o_matched_bases == '0), "index or code given without an answer")
    `BWM_ASSERT_NOW(a_answer_has_index, i_clk, i_rst_n, o_valid && ((o_status == STATUS_EXACT) || (o_status == STATUS_CORR)), o_match_index != '0, "answer without a slot")

endmodule

// ===== tb/bwm_tb_pkg.sv =====
// Scoreboard for the barcode whitelist matcher testbench: a shadow whitelist and a
// queue of predicted query answers. Depends on bwm_pkg.
package bwm_tb_pkg;

    import bwm_pkg::*;

    localparam int WL_SLOTS = 4096;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [BASES_W-1:0]  code;
    } t_match_answer;

    class match_scoreboard;
        logic [BASES_W-1:0] codes [WL_SLOTS];
        bit                 live [WL_SLOTS];
        logic [LEN_W-1:0]   len_reg;
        logic [COUNT_W-1:0] count_reg;
        t_match_answer      expected_answers [$];
        int                 mismatches;
        int                 loads_seen;
        int                 queries_seen;
        int                 cfg_writes;
        int                 status_seen [4];

        function new();
            foreach (codes[i]) begin
                codes[i] = '0;
                live[i]  = 1'b0;
            end
            foreach (status_seen[i]) status_seen[i] = 0;
            len_reg      = LEN_W'(16);
            count_reg    = '0;
            mismatches   = 0;
            loads_seen   = 0;
            queries_seen = 0;
            cfg_writes   = 0;
        endfunction

        function void write_register(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
            cfg_writes++;
            case (idx)
                CFG_BARCODE_LENGTH: len_reg = data[LEN_W-1:0];
                CFG_ENTRY_COUNT:    count_reg = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [BASES_W-1:0] length_mask();
            int n;
            n = int'(len_reg);
            if (n < 1) n = 1;
            if (n > MAX_BASES) n = MAX_BASES;
            if (n >= 32) return '1;
            return (BASES_W'(1) << (2 * n)) - BASES_W'(1);
        endfunction

        // fold each 2-bit base difference onto its low bit, then count bases
        function bit one_base_off(input logic [BASES_W-1:0] a, input logic [BASES_W-1:0] b);
            logic [BASES_W-1:0] d;
            logic [BASES_W-1:0] per_base;
            d        = a ^ b;
            per_base = (d | (d >> 1)) & BASE_LSB_MASK;
            return $countones(per_base) == 1;
        endfunction

        function t_match_answer predict_match(input logic [BASES_W-1:0] bases, input bit other);
            t_match_answer      ans;
            logic [BASES_W-1:0] m;
            logic [BASES_W-1:0] q;
            logic [BASES_W-1:0] c;
            logic [BASES_W-1:0] near_code;
            int                 lim;
            int                 exact_slot;
            int                 near_slot;
            bit                 exact_hit;
            bit                 near_hit;
            bit                 amb;
            ans = '0;
            if (other) return ans;
            m          = length_mask();
            q          = bases & m;
            lim        = int'(count_reg);
            if (lim > WL_SLOTS) lim = WL_SLOTS;
            exact_hit  = 1'b0;
            near_hit   = 1'b0;
            amb        = 1'b0;
            exact_slot = 0;
            near_slot  = 0;
            near_code  = '0;
            for (int s = 0; s < lim; s++) begin
                if (live[s]) begin
                    c = codes[s] & m;
                    if (c == q) begin
                        exact_hit  = 1'b1;
                        exact_slot = s;
                    end else if (one_base_off(c, q)) begin
                        if (!near_hit) begin
                            near_hit  = 1'b1;
                            near_code = c;
                            near_slot = s;
                        end else if (c == near_code) begin
                            near_slot = s;
                        end else begin
                            amb = 1'b1;
                        end
                    end
                end
            end
            if (exact_hit) begin
                ans.status = STATUS_EXACT;
                ans.index  = INDEX_W'(exact_slot + 1);
                ans.code   = q;
            end else if (amb) begin
                ans.status = STATUS_AMBIG;
            end else if (near_hit) begin
                ans.status = STATUS_CORR;
                ans.index  = INDEX_W'(near_slot + 1);
                ans.code   = near_code;
            end
            return ans;
        endfunction

        function void note_item(input logic kind, input logic [SLOT_W-1:0] slot,
                                input logic [BASES_W-1:0] bases, input logic other);
            if (kind == KIND_LOAD) begin
                codes[slot] = bases;
                live[slot]  = !other;
                loads_seen++;
            end else begin
                expected_answers.insert(expected_answers.size(), predict_match(bases, other));
                queries_seen++;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        function void flag(input string what, input logic [BASES_W-1:0] want,
                           input logic [BASES_W-1:0] got, input longint unsigned stamp);
            mismatches++;
            if (mismatches <= 50)
                $display("%0d ns: %s mismatch, expected %h actual %h", stamp, what, want, got);
        endfunction

        function void check_answer(input logic [STATUS_W-1:0] status,
                                   input logic [INDEX_W-1:0] index,
                                   input logic [BASES_W-1:0] code,
                                   input longint unsigned stamp);
            t_match_answer want;
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 50)
                    $display("%0d ns: result with no query outstanding, status %0d index %0d code %h",
                             stamp, status, index, code);
                return;
            end
            want = expected_answers.pop_front();
            status_seen[want.status]++;
            if (status !== want.status) flag("status", BASES_W'(want.status), BASES_W'(status), stamp);
            if (index !== want.index)   flag("match_index", BASES_W'(want.index), BASES_W'(index), stamp);
            if (code !== want.code)     flag("matched_bases", want.code, code, stamp);
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for barcode_whitelist_one_mismatch_match_top: drives loads, queries
// and register writes, and checks every answer. Depends on bwm_pkg and bwm_tb_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bwm_pkg::*;
    import bwm_tb_pkg::*;

    // a query sweeps 512 rows plus the cell chain; leave room for that
    localparam int DRAIN_CYCLES = 700;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int N_PHASES = 12;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_kind;
    logic [SLOT_W-1:0]      i_slot;
    logic [BASES_W-1:0]     i_bases;
    logic                   i_has_other_symbol;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [INDEX_W-1:0]     o_match_index;
    logic [BASES_W-1:0]     o_matched_bases;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    match_scoreboard    sb;
    int                 burst_left = 0;
    int                 stall_mode = 0;
    int                 stall_timer = 0;
    logic [BASES_W-1:0] recent_codes [$];

    int phase_len   [N_PHASES] = '{2, 1, 32, 3, 0, 63, 6, 16, 4, 31, 12, 5};
    int phase_count [N_PHASES] = '{24, 4096, 200, 8191, 40, 4096, 16, 1, 64, 4095, 300, 0};
    int phase_items [N_PHASES] = '{116, 116, 116, 116, 116, 116, 116, 116, 116, 116, 116, 40};

    barcode_whitelist_one_mismatch_match_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_slot             (i_slot),
        .i_bases            (i_bases),
        .i_has_other_symbol (i_has_other_symbol),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_match_index      (o_match_index),
        .o_matched_bases    (o_matched_bases),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver back-pressure: free-flowing, random, or long periodic stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (stall_timer == 0) begin
                stall_mode  = $urandom_range(0, 2);
                stall_timer = $urandom_range(16, 200);
            end else begin
                stall_timer--;
            end
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 99) < 40);
                default: i_stall <= ((stall_timer % 32) < 20);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_answer(o_status, o_match_index, o_matched_bases, $time);
    end

    // all driving tasks start and end just after a falling edge
    task automatic put_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic push_item(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [BASES_W-1:0] bases, input logic other);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        i_valid            <= 1'b1;
        i_kind             <= kind;
        i_slot             <= slot;
        i_bases            <= bases;
        i_has_other_symbol <= other;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(kind, slot, bases, other);
        burst_left--;
        @(negedge i_clk);
    endtask

    // idle the block: every answer back, then let a trailing load finish
    task automatic settle();
        i_valid    <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [BASES_W-1:0] flip_base(input logic [BASES_W-1:0] code, input int pos);
        return code ^ (BASES_W'($urandom_range(1, 3)) << (2 * pos));
    endfunction

    task automatic directed_checks();
        // default setting has no slots in use
        push_item(KIND_QUERY, '0, {$urandom, $urandom}, 1'b0);
        settle();
        put_cfg(CFG_BARCODE_LENGTH, CFG_DATA_W'(32));
        put_cfg(CFG_ENTRY_COUNT, CFG_DATA_W'(4096));
        push_item(KIND_LOAD, SLOT_W'(0), '1, 1'b0);
        push_item(KIND_LOAD, SLOT_W'(1), '1, 1'b0);
        push_item(KIND_LOAD, SLOT_W'(4095), '0, 1'b0);
        push_item(KIND_LOAD, SLOT_W'(3), 64'd1, 1'b0);
        push_item(KIND_LOAD, SLOT_W'(4), 64'd2, 1'b0);
        push_item(KIND_LOAD, SLOT_W'(5), 64'hDEAD_BEEF_0123_4567, 1'b1);
        push_item(KIND_QUERY, '0, '1, 1'b0);                      // duplicate, highest slot
        push_item(KIND_QUERY, '1, '0, 1'b0);                      // top slot
        push_item(KIND_QUERY, '0, '0, 1'b1);                      // non-ACGT query
        push_item(KIND_QUERY, '0, 64'hDEAD_BEEF_0123_4567, 1'b0); // slot loaded with N
        push_item(KIND_QUERY, '0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0); // last base corrected
        push_item(KIND_QUERY, '0, 64'd3, 1'b0);                   // three codes one base away
        push_item(KIND_QUERY, '0, 64'd1, 1'b0);
        settle();
        put_cfg(CFG_SPARE_A, '1);
        put_cfg(CFG_SPARE_B, '0);
        put_cfg(CFG_BARCODE_LENGTH, CFG_DATA_W'(0));    // acts as one base
        put_cfg(CFG_ENTRY_COUNT, CFG_DATA_W'(8191));    // clamps to full depth
        push_item(KIND_QUERY, '0, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0);
        push_item(KIND_QUERY, '0, 64'h0123_4567_89AB_CDEF, 1'b0);
        settle();
        put_cfg(CFG_BARCODE_LENGTH, CFG_DATA_W'(63));   // clamps to 32 bases
        push_item(KIND_QUERY, '0, '1, 1'b0);
        settle();
        // upper data bits dropped: length 4, stored codes now compared masked
        put_cfg(CFG_BARCODE_LENGTH, 13'h1044);
        put_cfg(CFG_ENTRY_COUNT, CFG_DATA_W'(6));
        push_item(KIND_QUERY, '0, 64'hFFFF_0000_0000_00FF, 1'b0);
        push_item(KIND_QUERY, '0, 64'hABCD_0000_0000_0001, 1'b0);
        push_item(KIND_QUERY, '0, 64'h0000_0000_0000_0005, 1'b0);
        settle();
    endtask

    task automatic random_phase(input int len_val, input int count_val, input int n_items);
        int                 eff;
        int                 live_slots;
        int                 pick;
        int                 p1;
        int                 p2;
        logic [BASES_W-1:0] outer;
        logic [BASES_W-1:0] code;
        logic [SLOT_W-1:0]  slot;
        logic               other;
        eff = len_val % 64;
        if (eff < 1) eff = 1;
        if (eff > MAX_BASES) eff = MAX_BASES;
        outer = (eff >= 32) ? '0 : ~((BASES_W'(1) << (2 * eff)) - BASES_W'(1));
        live_slots = (count_val > WL_SLOTS) ? WL_SLOTS : count_val;
        put_cfg(CFG_BARCODE_LENGTH, CFG_DATA_W'(len_val));
        put_cfg(CFG_ENTRY_COUNT, CFG_DATA_W'(count_val));
        recent_codes.delete();
        for (int i = 0; i < n_items; i++) begin
            code = {$urandom, $urandom};
            // mostly codes close to ones already loaded, so near hits and clashes happen
            if (recent_codes.size() > 0 && $urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, recent_codes.size() - 1);
                p1   = $urandom_range(0, eff - 1);
                p2   = (eff > 1) ? (p1 + $urandom_range(1, eff - 1)) % eff : p1;
                case ($urandom_range(0, 3))
                    0:       code = recent_codes[pick];
                    1, 2:    code = flip_base(recent_codes[pick], p1);
                    default: code = flip_base(flip_base(recent_codes[pick], p1), p2);
                endcase
                code = (code & ~outer) | ({$urandom, $urandom} & outer);
            end
            if (recent_codes.size() == 0 || $urandom_range(0, 1) == 0) begin
                slot = (live_slots > 0 && $urandom_range(0, 9) != 0) ?
                       SLOT_W'($urandom_range(0, live_slots - 1)) : SLOT_W'($urandom);
                other = ($urandom_range(0, 19) == 0);
                if (!other) begin
                    recent_codes.insert(recent_codes.size(), code);
                    if (recent_codes.size() > 48) void'(recent_codes.pop_front());
                end
                push_item(KIND_LOAD, slot, code, other);
            end else begin
                push_item(KIND_QUERY, SLOT_W'($urandom), code, $urandom_range(0, 14) == 0);
            end
        end
        settle();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_kind             = KIND_LOAD;
        i_slot             = '0;
        i_bases            = '0;
        i_has_other_symbol = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_index        = CFG_BARCODE_LENGTH;
        i_cfg_data         = '0;
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_checks();
        for (int p = 0; p < N_PHASES; p++)
            random_phase(phase_len[p], phase_count[p], phase_items[p]);
        $display("Ran %0d whitelist loads and %0d queries across %0d register writes.",
                 sb.loads_seen, sb.queries_seen, sb.cfg_writes);
        $display("Answers checked: %0d exact, %0d corrected, %0d ambiguous, %0d unmatched.",
                 sb.status_seen[STATUS_EXACT], sb.status_seen[STATUS_CORR],
                 sb.status_seen[STATUS_AMBIG], sb.status_seen[STATUS_NONE]);
        if (sb.mismatches == 0) begin
            $display("** barcode_whitelist_one_mismatch_match_top: PASSED **");
        end else begin
            $display("** barcode_whitelist_one_mismatch_match_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("Timeout with %0d answers outstanding", sb.pending());
        $display("** barcode_whitelist_one_mismatch_match_top: FAILED **");
        $finish;
    end

endmodule
